### rtl/yrgb_pkg.sv
package yrgb_pkg;

   // unsigned q1.16 conversion coefficients
   localparam logic [16:0] COEF_R  = 17'd89831;
   localparam logic [16:0] COEF_GV = 17'd45744;
   localparam logic [16:0] COEF_GU = 17'd22127;
   localparam logic [16:0] COEF_B  = 17'd113538;

   localparam logic [8:0] CHROMA_BIAS = 9'd128;
   localparam logic [8:0] GAIN_RESET  = 9'd220;
   localparam logic [7:0] CHAN_MAX    = 8'd255;

   localparam int PROD_W = 25;
   localparam int GAIN_W = 9;

   typedef logic [7:0]                chan_type;
   typedef logic [GAIN_W-1:0]         gain_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic [8+GAIN_W-1:0]       scaled_type;

   // chroma products shared by both pixels of a macropixel
   typedef struct packed {
      prod_type r;
      prod_type gv;
      prod_type gu;
      prod_type b;
   } chroma_prod_type;

   // stage load enables handed to each pixel datapath
   typedef struct packed {
      logic en2;
      logic en3;
      logic en4;
   } pipe_ctrl_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } rgb_type;

endpackage

### rtl/yrgb_if.sv
interface yrgb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_first;
   logic [7:0] chroma_blue;
   logic [7:0] luma_second;
   logic [7:0] chroma_red;
   logic       frame_end_in;

   modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                   frame_end_in, input ready);
   modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                 frame_end_in, output ready);
endinterface

interface yrgb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_first;
   logic [7:0] green_first;
   logic [7:0] blue_first;
   logic [7:0] red_second;
   logic [7:0] green_second;
   logic [7:0] blue_second;
   logic       frame_end_out;

   modport source (output valid, red_first, green_first, blue_first, red_second,
                   green_second, blue_second, frame_end_out, input ready);
   modport sink (input valid, red_first, green_first, blue_first, red_second,
                 green_second, blue_second, frame_end_out, output ready);
endinterface

interface yrgb_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### rtl/yrgb_pixel.sv
module yrgb_pixel (
   input  logic                     clock,
   input  yrgb_pkg::pipe_ctrl_type  ctrl,
   input  yrgb_pkg::chroma_prod_type prod,
   input  yrgb_pkg::chan_type       luma,
   input  yrgb_pkg::gain_type       gain,
   output yrgb_pkg::rgb_type        pixel
);

   localparam int PROD_W_LOC = yrgb_pkg::PROD_W + 1;
   logic signed [PROD_W_LOC-1:0] g_sum;

   logic signed [9:0] r_sum;
   logic signed [9:0] g_sum_y;
   logic signed [9:0] b_sum;
   logic signed [9:0] luma_ext;

   yrgb_pkg::chan_type   r_clamp_in, g_clamp_in, b_clamp_in;
   yrgb_pkg::chan_type   r_clamp_ff, g_clamp_ff, b_clamp_ff;
   yrgb_pkg::scaled_type r_scaled_ff, g_scaled_ff, b_scaled_ff;
   yrgb_pkg::rgb_type    pixel_in, pixel_ff;

   function automatic yrgb_pkg::chan_type clamp_chan(input logic signed [9:0] v);
      yrgb_pkg::chan_type c;
      if (v[9]) begin
         c = 8'd0;
      end else if (v[8]) begin
         c = yrgb_pkg::CHAN_MAX;
      end else begin
         c = v[7:0];
      end
      return c;
   endfunction

   function automatic yrgb_pkg::chan_type sat_chan(input yrgb_pkg::scaled_type s);
      logic [8:0] q;
      q = s[16:8];
      return q[8] ? yrgb_pkg::CHAN_MAX : q[7:0];
   endfunction

   // stage 2: green sum, floor by 2^16, add luma, clamp
   always_comb begin
      luma_ext = $signed({2'b00, luma});
      g_sum    = -$signed({prod.gv[yrgb_pkg::PROD_W-1], prod.gv})
                 - $signed({prod.gu[yrgb_pkg::PROD_W-1], prod.gu});
      r_sum    = luma_ext + {prod.r[yrgb_pkg::PROD_W-1], prod.r[24:16]};
      g_sum_y  = luma_ext + g_sum[25:16];
      b_sum    = luma_ext + {prod.b[yrgb_pkg::PROD_W-1], prod.b[24:16]};
      r_clamp_in = clamp_chan(r_sum);
      g_clamp_in = clamp_chan(g_sum_y);
      b_clamp_in = clamp_chan(b_sum);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en2) begin
         r_clamp_ff <= r_clamp_in;
         g_clamp_ff <= g_clamp_in;
         b_clamp_ff <= b_clamp_in;
      end
   end

   // stage 3: gain multiply
   always_ff @(posedge clock) begin
      if (ctrl.en3) begin
         r_scaled_ff <= r_clamp_ff * gain;
         g_scaled_ff <= g_clamp_ff * gain;
         b_scaled_ff <= b_clamp_ff * gain;
      end
   end

   // stage 4: divide by 256 and saturate
   always_comb begin
      pixel_in.red   = sat_chan(r_scaled_ff);
      pixel_in.green = sat_chan(g_scaled_ff);
      pixel_in.blue  = sat_chan(b_scaled_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en4) begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel = pixel_ff;

endmodule

### rtl/yuyv_to_rgb888_converter_top.sv
// throughput: one macropixel per cycle while rsp is ready, four pipeline stages with valid bits
// stage 1 chroma multiplies, stage 2 floor/add/clamp, stage 3 gain multiply,
// stage 4 scale, saturate and output register; rsp stall holds the full stages
// reset: synchronous, active high; empties the pipeline, gain register to 220
module yuyv_to_rgb888_converter_top (
   input  logic              clock,
   input  logic              reset,
   yrgb_req_if.sink          req,
   yrgb_rsp_if.source        rsp,
   yrgb_csr_if.sink          csr
);

   yrgb_pkg::gain_type        gain_ff;
   logic                      v1_ff, v2_ff, v3_ff, v4_ff;
   logic                      fe1_ff, fe2_ff, fe3_ff, fe4_ff;
   logic                      en1, en2, en3, en4;
   yrgb_pkg::pipe_ctrl_type   ctrl;
   yrgb_pkg::chroma_prod_type prod_in, prod_ff;
   yrgb_pkg::chan_type        y0_ff, y1_ff;
   yrgb_pkg::rgb_type         pix0, pix1;
   logic signed [8:0]         du, dv;
   logic signed [26:0]        pr_full, pgv_full, pgu_full, pb_full;

   // gain register, always ready
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= yrgb_pkg::GAIN_RESET;
      end else if (csr.valid) begin
         gain_ff <= csr.data;
      end
   end

   // stage enables: a stage loads when empty or when its successor moves
   assign en4 = !v4_ff || rsp.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req.ready = en1;

   assign ctrl.en2 = en2;
   assign ctrl.en3 = en3;
   assign ctrl.en4 = en4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // frame-end flag rides along
   always_ff @(posedge clock) begin
      if (en1) fe1_ff <= req.frame_end_in;
      if (en2) fe2_ff <= fe1_ff;
      if (en3) fe3_ff <= fe2_ff;
      if (en4) fe4_ff <= fe3_ff;
   end

   // stage 1: centered chroma times q1.16 coefficients
   always_comb begin
      du       = $signed({1'b0, req.chroma_blue}) - $signed(yrgb_pkg::CHROMA_BIAS);
      dv       = $signed({1'b0, req.chroma_red}) - $signed(yrgb_pkg::CHROMA_BIAS);
      pr_full  = dv * $signed({1'b0, yrgb_pkg::COEF_R});
      pgv_full = dv * $signed({1'b0, yrgb_pkg::COEF_GV});
      pgu_full = du * $signed({1'b0, yrgb_pkg::COEF_GU});
      pb_full  = du * $signed({1'b0, yrgb_pkg::COEF_B});
      prod_in.r  = pr_full[24:0];
      prod_in.gv = pgv_full[24:0];
      prod_in.gu = pgu_full[24:0];
      prod_in.b  = pb_full[24:0];
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         prod_ff <= prod_in;
         y0_ff   <= req.luma_first;
         y1_ff   <= req.luma_second;
      end
   end

   // stages 2 to 4, one datapath per pixel
   yrgb_pixel u_pixel_first (
      .clock (clock),
      .ctrl  (ctrl),
      .prod  (prod_ff),
      .luma  (y0_ff),
      .gain  (gain_ff),
      .pixel (pix0)
   );

   yrgb_pixel u_pixel_second (
      .clock (clock),
      .ctrl  (ctrl),
      .prod  (prod_ff),
      .luma  (y1_ff),
      .gain  (gain_ff),
      .pixel (pix1)
   );

   // result beat
   assign rsp.valid         = v4_ff;
   assign rsp.red_first     = pix0.red;
   assign rsp.green_first   = pix0.green;
   assign rsp.blue_first    = pix0.blue;
   assign rsp.red_second    = pix1.red;
   assign rsp.green_second  = pix1.green;
   assign rsp.blue_second   = pix1.blue;
   assign rsp.frame_end_out = fe4_ff;

endmodule
